FILE: design/psg_pkg.sv
`timescale 1ns / 1ps

package psg_pkg;

    localparam int HP_W    = 10;
    localparam int SCALE_W = 16;
    localparam int CNT_W   = 10;
    localparam int ATT_W   = 4;
    localparam int LFSR_W  = 15;
    localparam int NUM_CH  = 4;
    localparam int NUM_TONE = 3;

    localparam logic [SCALE_W-1:0] PERIOD_SCALE_RESET = 16'd11561;
    localparam logic [LFSR_W-1:0]  LFSR_RESET         = 15'h4000;
    localparam logic [CNT_W-1:0]   CNT_MAX            = 10'd1023;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [2:0] REG_NOISE_RATE = 3'd6;

    localparam logic [1:0] NOISE_RATE_FAST   = 2'd0;
    localparam logic [1:0] NOISE_RATE_MID    = 2'd1;
    localparam logic [1:0] NOISE_RATE_SLOW   = 2'd2;
    localparam logic [1:0] NOISE_RATE_FOLLOW = 2'd3;

    localparam logic [CNT_W-1:0] NOISE_RELOAD_FAST = 10'd86;
    localparam logic [CNT_W-1:0] NOISE_RELOAD_MID  = 10'd43;
    localparam logic [CNT_W-1:0] NOISE_RELOAD_SLOW = 10'd22;

    localparam logic [1:0] CH_NOISE = 2'd0;
    localparam logic [1:0] CH_TONE1 = 2'd1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } psg_in_t;

    typedef struct packed {
        logic       sample_valid;
        logic [7:0] sample;
        logic       bad_write;
    } psg_out_t;

endpackage

FILE: design/psg_reload.sv
`timescale 1ns / 1ps

module psg_reload #(
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic [psg_pkg::HP_W-1:0]    half_period,
    input  logic [psg_pkg::SCALE_W-1:0] period_scale,
    output logic [psg_pkg::CNT_W-1:0]   reload
);

    localparam int PROD_W = psg_pkg::HP_W + psg_pkg::SCALE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  rounded;
    logic [SUM_W-1:0]  shifted;

    assign prod    = PROD_W'(half_period) * PROD_W'(period_scale);
    assign rounded = {1'b0, prod} + (SUM_W'(1) << (SCALE_FRAC_BITS - 1));
    assign shifted = rounded >> SCALE_FRAC_BITS;

    always_comb
    begin
        priority if (shifted == '0)
        begin
            reload = psg_pkg::CNT_W'(1);
        end
        else if (shifted > SUM_W'(psg_pkg::CNT_MAX))
        begin
            reload = psg_pkg::CNT_MAX;
        end
        else
        begin
            reload = shifted[psg_pkg::CNT_W-1:0];
        end
    end

endmodule

FILE: design/psg_core.sv
`timescale 1ns / 1ps

module psg_core #(
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  psg_pkg::psg_in_t             item,
    input  logic [psg_pkg::SCALE_W-1:0]  period_scale,
    output psg_pkg::psg_out_t            result
);

    logic [2:0]                                          latched_reg;
    logic [2:0]                                          latched_next;
    logic [psg_pkg::NUM_TONE-1:0][psg_pkg::HP_W-1:0]     half_period_reg;
    logic [psg_pkg::NUM_TONE-1:0][psg_pkg::HP_W-1:0]     half_period_next;
    logic [psg_pkg::NUM_CH-1:0][psg_pkg::CNT_W-1:0]      reload_reg;
    logic [psg_pkg::NUM_CH-1:0][psg_pkg::CNT_W-1:0]      reload_next;
    logic [psg_pkg::NUM_CH-1:0][psg_pkg::CNT_W-1:0]      counter_reg;
    logic [psg_pkg::NUM_CH-1:0][psg_pkg::CNT_W-1:0]      counter_next;
    logic [psg_pkg::NUM_CH-1:0]                          level_reg;
    logic [psg_pkg::NUM_CH-1:0]                          level_next;
    logic [psg_pkg::NUM_CH-1:0][psg_pkg::ATT_W-1:0]      att_reg;
    logic [psg_pkg::NUM_CH-1:0][psg_pkg::ATT_W-1:0]      att_next;
    logic                                                follow_reg;
    logic                                                follow_next;
    logic [psg_pkg::LFSR_W-1:0]                          lfsr_reg;
    logic [psg_pkg::LFSR_W-1:0]                          lfsr_next;

    logic [1:0]                  data_chan;
    logic [1:0]                  data_hp_idx;
    logic [psg_pkg::HP_W-1:0]    data_hp;
    logic [psg_pkg::CNT_W-1:0]   data_reload;

    // data bytes use the register latched earlier
    assign data_chan   = 2'd3 - latched_reg[2:1];
    assign data_hp_idx = data_chan - 2'd1;
    assign data_hp     = {item.data_byte[5:0], half_period_reg[data_hp_idx][3:0]};

    psg_reload #(
        .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
    ) u_reload (
        .half_period  (data_hp),
        .period_scale (period_scale),
        .reload       (data_reload)
    );

    always_comb
    begin
        logic [2:0] new_reg;
        logic [1:0] chan;
        logic [1:0] hp_idx;
        logic [7:0] sum;

        latched_next     = latched_reg;
        half_period_next = half_period_reg;
        reload_next      = reload_reg;
        counter_next     = counter_reg;
        level_next       = level_reg;
        att_next         = att_reg;
        follow_next      = follow_reg;
        lfsr_next        = lfsr_reg;
        result           = '0;
        new_reg          = item.data_byte[6:4];
        chan             = 2'd3 - new_reg[2:1];
        hp_idx           = chan - 2'd1;
        sum              = '0;

        if (step)
        begin
            if (item.op == psg_pkg::OP_TICK)
            begin
                for (int c = 0; c < psg_pkg::NUM_CH; c++)
                begin
                    if (counter_reg[c] == '0)
                    begin
                        counter_next[c] = reload_reg[c];
                        if (c == 0)
                        begin
                            level_next[c] = lfsr_reg[0];
                            lfsr_next = {lfsr_reg[0] ^ lfsr_reg[1],
                                         lfsr_reg[psg_pkg::LFSR_W-1:1]};
                        end
                        else
                        begin
                            level_next[c] = ~level_reg[c];
                        end
                    end
                    else
                    begin
                        counter_next[c] = counter_reg[c] - psg_pkg::CNT_W'(1);
                    end
                    if (level_next[c])
                    begin
                        sum = sum + {2'b00, att_reg[c], 2'b00};
                    end
                end
                result.sample_valid = 1'b1;
                result.sample       = sum;
            end
            else if (item.data_byte[7])
            begin
                latched_next = new_reg;
                if (new_reg[0])
                begin
                    att_next[chan] = ~item.data_byte[3:0];
                end
                else if (chan == psg_pkg::CH_NOISE)
                begin
                    unique case (item.data_byte[1:0])
                        psg_pkg::NOISE_RATE_FAST:
                        begin
                            reload_next[0] = psg_pkg::NOISE_RELOAD_FAST;
                            follow_next    = 1'b0;
                        end
                        psg_pkg::NOISE_RATE_MID:
                        begin
                            reload_next[0] = psg_pkg::NOISE_RELOAD_MID;
                            follow_next    = 1'b0;
                        end
                        psg_pkg::NOISE_RATE_SLOW:
                        begin
                            reload_next[0] = psg_pkg::NOISE_RELOAD_SLOW;
                            follow_next    = 1'b0;
                        end
                        psg_pkg::NOISE_RATE_FOLLOW:
                        begin
                            reload_next[0] = reload_reg[1];
                            follow_next    = 1'b1;
                        end
                        default:
                        begin
                            reload_next[0] = reload_reg[0];
                        end
                    endcase
                    counter_next[0] = '0;
                    level_next[0]   = 1'b0;
                end
                else
                begin
                    half_period_next[hp_idx] = {half_period_reg[hp_idx][psg_pkg::HP_W-1:4],
                                                item.data_byte[3:0]};
                end
            end
            else
            begin
                if (latched_reg[0] || latched_reg >= psg_pkg::REG_NOISE_RATE)
                begin
                    result.bad_write = 1'b1;
                end
                else
                begin
                    half_period_next[data_hp_idx] = data_hp;
                    reload_next[data_chan]        = data_reload;
                    counter_next[data_chan]       = '0;
                    level_next[data_chan]         = 1'b0;
                    if (follow_reg && data_chan == psg_pkg::CH_TONE1)
                    begin
                        reload_next[0]  = data_reload;
                        counter_next[0] = '0;
                        level_next[0]   = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg     <= '0;
            half_period_reg <= '0;
            reload_reg      <= '0;
            counter_reg     <= '0;
            level_reg       <= '0;
            att_reg         <= '0;
            follow_reg      <= 1'b0;
            lfsr_reg        <= psg_pkg::LFSR_RESET;
        end
        else
        begin
            latched_reg     <= latched_next;
            half_period_reg <= half_period_next;
            reload_reg      <= reload_next;
            counter_reg     <= counter_next;
            level_reg       <= level_next;
            att_reg         <= att_next;
            follow_reg      <= follow_next;
            lfsr_reg        <= lfsr_next;
        end
    end

endmodule

FILE: design/psg_tone_noise_synth_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        in         in_valid / in_ready    in_item (op, data_byte)
// out       out        out_valid / out_ready  out_item (sample_valid, sample, bad_write)
// cfg       in         cfg_we                 cfg_wdata (period_scale)
//
// an item is held in the input register, its result is captured in the output register
// one item per cycle sustained while results are taken; the period multiply sits between input and result registers
// reset clears all channel state, the noise shift register loads 0x4000
// a stalled result holds the output register; the input register takes one more item,
// then in_ready drops until the result is taken

module psg_tone_noise_synth_top #(
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  psg_pkg::psg_in_t             in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output psg_pkg::psg_out_t            out_item,
    input  logic                         cfg_we,
    input  logic [psg_pkg::SCALE_W-1:0]  cfg_wdata
);

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    psg_pkg::psg_in_t             s1_item_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    psg_pkg::psg_out_t            out_item_reg;
    logic [psg_pkg::SCALE_W-1:0]  scale_reg;
    logic [psg_pkg::SCALE_W-1:0]  scale_next;

    logic              out_free;
    logic              s1_advance;
    logic              in_take;
    psg_pkg::psg_out_t core_result;

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_take    = in_valid && in_ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && !out_ready);
    assign scale_next     = cfg_we ? cfg_wdata : scale_reg;

    psg_core #(
        .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_advance),
        .item         (s1_item_reg),
        .period_scale (scale_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scale_reg     <= psg_pkg::PERIOD_SCALE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            scale_reg     <= scale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_advance)
        begin
            out_item_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: tb/tb_psg_tone_noise_synth_top.sv
`timescale 1ns / 1ps

module tb_psg_tone_noise_synth_top;

    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_ITEMS = 260;

    localparam logic [2:0] REG_TONE3_PERIOD = 3'd0;
    localparam logic [2:0] REG_TONE3_ATT    = 3'd1;
    localparam logic [2:0] REG_TONE2_PERIOD = 3'd2;
    localparam logic [2:0] REG_TONE2_ATT    = 3'd3;
    localparam logic [2:0] REG_TONE1_PERIOD = 3'd4;
    localparam logic [2:0] REG_TONE1_ATT    = 3'd5;
    localparam logic [2:0] REG_NOISE_ATT    = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    psg_pkg::psg_in_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    psg_pkg::psg_out_t out_item;
    logic cfg_we = 1'b0;
    logic [psg_pkg::SCALE_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [psg_pkg::SCALE_W-1:0] cur_scale;
    logic [2:0]                  cur_latch;
    logic [psg_pkg::HP_W-1:0]    tone_half [psg_pkg::NUM_TONE];
    logic [psg_pkg::CNT_W-1:0]   ch_reload [psg_pkg::NUM_CH];
    logic [psg_pkg::CNT_W-1:0]   ch_count  [psg_pkg::NUM_CH];
    logic                        ch_level  [psg_pkg::NUM_CH];
    logic [psg_pkg::ATT_W-1:0]   ch_atten  [psg_pkg::NUM_CH];
    logic                        noise_follow;
    logic [psg_pkg::LFSR_W-1:0]  noise_lfsr;

    psg_pkg::psg_out_t sample_due[$];
    int mismatch_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int send_max = 0;
    int recv_max = 0;
    int recv_wait = 0;
    int hold_off = 0;

    psg_tone_noise_synth_top #(
        .SCALE_FRAC_BITS(FRAC_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("psg_tone_noise_synth_top regression: fail");
            $finish;
        end
    end

    function automatic logic [psg_pkg::CNT_W-1:0] scaled_reload(logic [psg_pkg::HP_W-1:0] hp);
        logic [63:0] acc;
        acc = 64'(hp) * 64'(cur_scale) + (64'd1 << (FRAC_BITS - 1));
        acc = acc >> FRAC_BITS;
        if (acc == 0)
            return psg_pkg::CNT_W'(1);
        if (acc > 64'(psg_pkg::CNT_MAX))
            return psg_pkg::CNT_MAX;
        return acc[psg_pkg::CNT_W-1:0];
    endfunction

    function automatic void reset_synth_state();
        cur_scale = psg_pkg::PERIOD_SCALE_RESET;
        cur_latch = '0;
        for (int i = 0; i < psg_pkg::NUM_TONE; i++)
            tone_half[i] = '0;
        for (int i = 0; i < psg_pkg::NUM_CH; i++)
        begin
            ch_reload[i] = '0;
            ch_count[i]  = '0;
            ch_level[i]  = 1'b0;
            ch_atten[i]  = '0;
        end
        noise_follow = 1'b0;
        noise_lfsr   = psg_pkg::LFSR_RESET;
    endfunction

    function automatic psg_pkg::psg_out_t synth_step(psg_pkg::psg_in_t it);
        psg_pkg::psg_out_t r;
        logic [9:0] mix;
        int ch;
        r = '0;
        if (it.op == psg_pkg::OP_TICK)
        begin
            mix = '0;
            for (int c = 0; c < psg_pkg::NUM_CH; c++)
            begin
                if (ch_count[c] == 0)
                begin
                    ch_count[c] = ch_reload[c];
                    if (c != psg_pkg::CH_NOISE)
                        ch_level[c] = ~ch_level[c];
                    else
                    begin
                        ch_level[c] = noise_lfsr[0];
                        noise_lfsr  = {noise_lfsr[0] ^ noise_lfsr[1],
                                       noise_lfsr[psg_pkg::LFSR_W-1:1]};
                    end
                end
                else
                    ch_count[c] = ch_count[c] - 1'b1;
                if (ch_level[c])
                    mix = mix + {4'b0, ch_atten[c], 2'b00};
            end
            r.sample_valid = 1'b1;
            r.sample       = mix[7:0];
        end
        else if (it.data_byte[7])
        begin
            cur_latch = it.data_byte[6:4];
            ch = psg_pkg::NUM_CH - 1 - int'(cur_latch[2:1]);
            if (cur_latch[0])
                ch_atten[ch] = it.data_byte[3:0] ^ 4'hf;
            else if (cur_latch == psg_pkg::REG_NOISE_RATE)
            begin
                case (it.data_byte[1:0])
                    psg_pkg::NOISE_RATE_FAST:
                        ch_reload[psg_pkg::CH_NOISE] = psg_pkg::NOISE_RELOAD_FAST;
                    psg_pkg::NOISE_RATE_MID:
                        ch_reload[psg_pkg::CH_NOISE] = psg_pkg::NOISE_RELOAD_MID;
                    psg_pkg::NOISE_RATE_SLOW:
                        ch_reload[psg_pkg::CH_NOISE] = psg_pkg::NOISE_RELOAD_SLOW;
                    default:
                        ch_reload[psg_pkg::CH_NOISE] = ch_reload[psg_pkg::CH_TONE1];
                endcase
                noise_follow = (it.data_byte[1:0] == psg_pkg::NOISE_RATE_FOLLOW);
                ch_count[psg_pkg::CH_NOISE] = '0;
                ch_level[psg_pkg::CH_NOISE] = 1'b0;
            end
            else
                tone_half[ch-1][3:0] = it.data_byte[3:0];
        end
        else if (cur_latch[0] || cur_latch >= psg_pkg::REG_NOISE_RATE)
            r.bad_write = 1'b1;
        else
        begin
            ch = psg_pkg::NUM_CH - 1 - int'(cur_latch[2:1]);
            tone_half[ch-1][9:4] = it.data_byte[5:0];
            ch_reload[ch] = scaled_reload(tone_half[ch-1]);
            ch_count[ch]  = '0;
            ch_level[ch]  = 1'b0;
            if (noise_follow && ch == psg_pkg::CH_TONE1)
            begin
                ch_reload[psg_pkg::CH_NOISE] = ch_reload[psg_pkg::CH_TONE1];
                ch_count[psg_pkg::CH_NOISE]  = '0;
                ch_level[psg_pkg::CH_NOISE]  = 1'b0;
            end
        end
        return r;
    endfunction

    // result side: stall control and checking
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            out_ready <= 1'b0;
        end
        else if (recv_wait > 0)
        begin
            recv_wait--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        psg_pkg::psg_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sample_due.size() == 0)
            begin
                $error("unexpected item: %p", out_item);
                mismatch_count++;
            end
            else
            begin
                want = sample_due.pop_front();
                if (out_item.sample_valid !== want.sample_valid)
                begin
                    $error("sample_valid: expected %0d, got %0d",
                           want.sample_valid, out_item.sample_valid);
                    mismatch_count++;
                end
                if (out_item.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", want.sample, out_item.sample);
                    mismatch_count++;
                end
                if (out_item.bad_write !== want.bad_write)
                begin
                    $error("bad_write: expected %0d, got %0d",
                           want.bad_write, out_item.bad_write);
                    mismatch_count++;
                end
            end
            recv_wait = (recv_max > 0) ? $urandom_range(0, recv_max) : 0;
        end
    end

    task automatic issue_item(psg_pkg::psg_in_t it);
        int gap;
        gap = (send_max > 0) ? $urandom_range(0, send_max) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sample_due.push_back(synth_step(it));
        items_sent++;
    endtask

    task automatic write_cmd(logic [7:0] b);
        psg_pkg::psg_in_t it;
        it.op = psg_pkg::OP_WRITE;
        it.data_byte = b;
        issue_item(it);
    endtask

    task automatic tick_n(int n);
        psg_pkg::psg_in_t it;
        for (int i = 0; i < n; i++)
        begin
            it.op = psg_pkg::OP_TICK;
            it.data_byte = 8'($urandom);
            issue_item(it);
        end
    endtask

    function automatic logic [7:0] latch_byte(logic [2:0] rsel, logic [3:0] nib);
        return {1'b1, rsel, nib};
    endfunction

    function automatic logic [7:0] data_byte_of(logic [6:0] bits);
        return {1'b0, bits};
    endfunction

    task automatic drain_samples();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sample_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_scale(logic [psg_pkg::SCALE_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_scale = v;
    endtask

    task automatic test_power_on();
        tick_n(3);
        write_cmd(data_byte_of(7'h00));
        tick_n(2);
    endtask

    task automatic test_tone_and_volume();
        write_cmd(latch_byte(REG_TONE3_ATT, 4'h0));
        write_cmd(latch_byte(REG_NOISE_ATT, 4'hf));
        write_cmd(latch_byte(REG_TONE3_PERIOD, 4'hf));
        write_cmd(data_byte_of(7'h7f));
        write_cmd(latch_byte(REG_TONE2_PERIOD, 4'h0));
        write_cmd(data_byte_of(7'h00));
        write_cmd(latch_byte(REG_TONE2_ATT, 4'h7));
        write_cmd(latch_byte(REG_TONE1_ATT, 4'h0));
        write_cmd(latch_byte(REG_TONE1_PERIOD, 4'h3));
        tick_n(4);
    endtask

    task automatic test_noise_and_bad_writes();
        write_cmd(latch_byte(REG_NOISE_ATT, 4'h0));
        write_cmd(latch_byte(psg_pkg::REG_NOISE_RATE, 4'h0));
        write_cmd(latch_byte(psg_pkg::REG_NOISE_RATE, 4'h5));
        write_cmd(latch_byte(psg_pkg::REG_NOISE_RATE, 4'ha));
        write_cmd(data_byte_of(7'h55));
        write_cmd(latch_byte(psg_pkg::REG_NOISE_RATE, 4'hf));
        write_cmd(latch_byte(REG_TONE1_PERIOD, 4'h1));
        write_cmd(data_byte_of(7'h00));
        tick_n(6);
        write_cmd(latch_byte(REG_TONE2_ATT, 4'h2));
        write_cmd(data_byte_of(7'h2a));
        write_cmd(latch_byte(psg_pkg::REG_NOISE_RATE, 4'hc));
        tick_n(3);
    endtask

    task automatic test_scale_extremes();
        logic [psg_pkg::SCALE_W-1:0] scales [3];
        scales = '{16'h0000, 16'hffff, psg_pkg::PERIOD_SCALE_RESET};
        foreach (scales[i])
        begin
            drain_samples();
            set_scale(scales[i]);
            write_cmd(latch_byte(REG_TONE1_PERIOD, 4'($urandom)));
            write_cmd(data_byte_of(7'($urandom_range(0, 3))));
            write_cmd(latch_byte(REG_TONE3_PERIOD, 4'hf));
            write_cmd(data_byte_of(7'h3f));
            write_cmd(latch_byte(REG_TONE1_ATT, 4'h0));
            tick_n(12);
        end
    endtask

    task automatic test_backpressure();
        drain_samples();
        send_max = 0;
        recv_max = 0;
        hold_off = 80;
        write_cmd(latch_byte(REG_TONE2_PERIOD, 4'h2));
        write_cmd(data_byte_of(7'h00));
        tick_n(20);
        // sender stops until every result is back
        drain_samples();
    endtask

    task automatic random_sequence();
        int kind;
        logic [2:0] rsel;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            rsel = 3'($urandom_range(0, 2)) << 1;
            write_cmd(latch_byte(rsel, 4'($urandom)));
            if ($urandom_range(0, 3) == 0)
                write_cmd(data_byte_of(7'($urandom)));
            else
                write_cmd(data_byte_of({6'($urandom_range(0, 1)) , 1'b0} | 7'($urandom) & 7'h40));
        end
        else if (kind < 40)
        begin
            rsel = {2'($urandom), 1'b1};
            write_cmd(latch_byte(rsel, 4'($urandom)));
        end
        else if (kind < 48)
            write_cmd(latch_byte(psg_pkg::REG_NOISE_RATE, 4'($urandom)));
        else if (kind < 90)
            tick_n($urandom_range(1, 16));
        else if (kind < 95)
            write_cmd(8'($urandom));
        else
        begin
            rsel = ($urandom_range(0, 1) == 0) ? psg_pkg::REG_NOISE_RATE
                                               : {2'($urandom), 1'b1};
            write_cmd(latch_byte(rsel, 4'($urandom)));
            write_cmd(data_byte_of(7'($urandom)));
        end
    endtask

    task automatic test_random();
        int stop_at;
        for (int p = 0; p < 4; p++)
        begin
            drain_samples();
            case (p)
                0: set_scale(16'($urandom));
                1: set_scale(16'($urandom_range(0, 255)));
                2: set_scale(16'($urandom_range(16'hf000, 16'hffff)));
                default: set_scale(16'($urandom));
            endcase
            send_max = (p == 1 || p == 2) ? 9 : 0;
            recv_max = (p == 1 || p == 3) ? 9 : 0;
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
                random_sequence();
        end
        send_max = 9;
        recv_max = 9;
    endtask

    initial
    begin
        reset_synth_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_max = 0;
        recv_max = 0;
        test_power_on();
        send_max = 9;
        recv_max = 9;
        test_tone_and_volume();
        test_noise_and_bad_writes();
        test_scale_extremes();
        test_backpressure();
        test_random();

        drain_samples();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && sample_due.size() == 0)
            $display("psg_tone_noise_synth_top regression: pass");
        else
            $display("psg_tone_noise_synth_top regression: fail");
        $finish;
    end

endmodule
